>>> rtl/aag_pkg.sv
`default_nettype none

package aag_pkg;

  localparam int DATA_W    = 32;
  localparam int ESIZE_W   = 31;
  localparam int ID_W      = 4;
  localparam int ID_VALUES = 16;
  localparam int DCNT_W    = 4;
  localparam int CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_DEFINE    = 2'd0,
    OP_BOUND     = 2'd1,
    OP_SUBSCRIPT = 2'd2
  } aag_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_CONST,
    ST_Q_MAC,
    ST_Q_EMIT,
    ST_FIN_RD,
    ST_FIN_SUM,
    ST_FIN_STR,
    ST_FIN_CONST
  } aag_state_e;

  typedef struct packed {
    logic clear_en;
    logic def_load;
    logic bound_load;
    logic fin_start;
    logic fin_sum;
    logic fin_str;
    logic fin_const;
    logic sub_accept;
    logic q_const;
    logic q_mac;
    logic out_load;
  } aag_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic defining;
    logic bound_last;
    logic dc_zero;
    logic emit;
    logic out_free;
    logic k_zero;
  } aag_status_t;

endpackage

`default_nettype wire

>>> rtl/aag_in_if.sv
`default_nettype none

interface aag_in_if;
  logic                                valid;
  logic                                ready;
  logic        [aag_pkg::CMD_W-1:0]    command;
  logic        [aag_pkg::ID_W-1:0]     array_id;
  logic signed [aag_pkg::DATA_W-1:0]   base_address;
  logic        [aag_pkg::ESIZE_W-1:0]  elem_bytes;
  logic        [aag_pkg::DCNT_W-1:0]   dim_count;
  logic signed [aag_pkg::DATA_W-1:0]   lower_bound;
  logic signed [aag_pkg::DATA_W-1:0]   upper_bound;
  logic signed [aag_pkg::DATA_W-1:0]   subscript;

  modport source (
    output valid, command, array_id, base_address, elem_bytes, dim_count,
           lower_bound, upper_bound, subscript,
    input  ready
  );

  modport sink (
    input  valid, command, array_id, base_address, elem_bytes, dim_count,
           lower_bound, upper_bound, subscript,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/aag_out_if.sv
`default_nettype none

interface aag_out_if;
  logic                              valid;
  logic                              ready;
  logic        [aag_pkg::ID_W-1:0]   array_id_res;
  logic signed [aag_pkg::DATA_W-1:0] address;

  modport source (
    output valid, array_id_res, address,
    input  ready
  );

  modport sink (
    input  valid, array_id_res, address,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/array_address_generator.sv
// Row-major array address generator. Define, bound and subscript requests arrive on in_i;
// element addresses leave on out_o, one per completed subscript run. After reset the
// coefficient memory is swept to zero, and no request is taken until it ends. A define
// request and a bound that does not close its definition leave the block idle. The
// bound that closes a definition holds the block while the stride and constant walk runs
// from the last dimension back to the first, with one multiply per dimension for the
// lower-bound sum and one per stride of each dimension but the last. A subscript request
// passes through the multiply-accumulate state, the first of a query also through a state
// that loads the constant it fetched. This sequencing comes from the single shared 32x32
// multiplier and the one registered read port of the coefficient memory. A finished address
// sits in an output register; if it has not been taken, the next one waits until it has.
`default_nettype none

module array_address_generator #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aag_in_if.sink     in_i,
  aag_out_if.source  out_o
);

  aag_pkg::aag_cmd_t    cmd;
  aag_pkg::aag_status_t status;

  aag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.command),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  aag_datapath #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .array_id_i         (in_i.array_id),
    .base_address_i     (in_i.base_address),
    .elem_bytes_i       (in_i.elem_bytes),
    .dim_count_i        (in_i.dim_count),
    .lower_bound_i      (in_i.lower_bound),
    .upper_bound_i      (in_i.upper_bound),
    .subscript_i        (in_i.subscript),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_array_id_res_o (out_o.array_id_res),
    .out_address_o      (out_o.address)
  );

endmodule

`default_nettype wire

>>> rtl/aag_ctrl.sv
`default_nettype none

module aag_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [aag_pkg::CMD_W-1:0]   op_i,
  input  aag_pkg::aag_status_t        status_i,
  output logic                        in_ready_o,
  output aag_pkg::aag_cmd_t           cmd_o
);

  aag_pkg::aag_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aag_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aag_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = aag_pkg::ST_IDLE;
      end
      aag_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            aag_pkg::OP_BOUND: begin
              if (status_i.defining && status_i.bound_last) state_d = aag_pkg::ST_FIN_RD;
            end
            aag_pkg::OP_SUBSCRIPT: begin
              state_d = status_i.dc_zero ? aag_pkg::ST_Q_CONST : aag_pkg::ST_Q_MAC;
            end
            default: state_d = aag_pkg::ST_IDLE;
          endcase
        end
      end
      aag_pkg::ST_Q_CONST: state_d = aag_pkg::ST_Q_MAC;
      aag_pkg::ST_Q_MAC: begin
        state_d = (status_i.emit && !status_i.out_free) ? aag_pkg::ST_Q_EMIT
                                                        : aag_pkg::ST_IDLE;
      end
      aag_pkg::ST_Q_EMIT: begin
        if (status_i.out_free) state_d = aag_pkg::ST_IDLE;
      end
      aag_pkg::ST_FIN_RD:  state_d = aag_pkg::ST_FIN_SUM;
      aag_pkg::ST_FIN_SUM: begin
        state_d = status_i.k_zero ? aag_pkg::ST_FIN_CONST : aag_pkg::ST_FIN_STR;
      end
      aag_pkg::ST_FIN_STR:   state_d = aag_pkg::ST_FIN_SUM;
      aag_pkg::ST_FIN_CONST: state_d = aag_pkg::ST_IDLE;
      default:               state_d = aag_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      aag_pkg::ST_CLEAR: cmd_o.clear_en = 1'b1;
      aag_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            aag_pkg::OP_DEFINE: cmd_o.def_load = 1'b1;
            aag_pkg::OP_BOUND: begin
              cmd_o.bound_load = status_i.defining;
              cmd_o.fin_start  = status_i.defining && status_i.bound_last;
            end
            aag_pkg::OP_SUBSCRIPT: cmd_o.sub_accept = 1'b1;
            default: cmd_o = '0;
          endcase
        end
      end
      aag_pkg::ST_Q_CONST: cmd_o.q_const = 1'b1;
      aag_pkg::ST_Q_MAC: begin
        cmd_o.q_mac    = 1'b1;
        cmd_o.out_load = status_i.emit && status_i.out_free;
      end
      aag_pkg::ST_Q_EMIT:    cmd_o.out_load  = status_i.out_free;
      aag_pkg::ST_FIN_RD:    cmd_o           = '0;
      aag_pkg::ST_FIN_SUM:   cmd_o.fin_sum   = 1'b1;
      aag_pkg::ST_FIN_STR:   cmd_o.fin_str   = 1'b1;
      aag_pkg::ST_FIN_CONST: cmd_o.fin_const = 1'b1;
      default:               cmd_o           = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/aag_datapath.sv
`default_nettype none

module aag_datapath #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aag_pkg::aag_cmd_t             cmd_i,
  output aag_pkg::aag_status_t          status_o,
  input  logic [aag_pkg::ID_W-1:0]      array_id_i,
  input  logic [aag_pkg::DATA_W-1:0]    base_address_i,
  input  logic [aag_pkg::ESIZE_W-1:0]   elem_bytes_i,
  input  logic [aag_pkg::DCNT_W-1:0]    dim_count_i,
  input  logic [aag_pkg::DATA_W-1:0]    lower_bound_i,
  input  logic [aag_pkg::DATA_W-1:0]    upper_bound_i,
  input  logic [aag_pkg::DATA_W-1:0]    subscript_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [aag_pkg::ID_W-1:0]      out_array_id_res_o,
  output logic [aag_pkg::DATA_W-1:0]    out_address_o
);

  localparam int ROW_WORDS   = MAX_DIMS + 1;
  localparam int TABLE_DEPTH = MAX_ARRAYS * ROW_WORDS;
  localparam int TAW         = $clog2(TABLE_DEPTH);
  localparam int AW          = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int KW          = $clog2(ROW_WORDS);
  localparam int DW          = $clog2(MAX_DIMS + 1);
  localparam int LW          = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int XW          = aag_pkg::DATA_W;

  function automatic logic [TAW-1:0] tab_addr(input logic [AW-1:0] row,
                                               input logic [KW-1:0] k);
    tab_addr = TAW'(row) * TAW'(ROW_WORDS) + TAW'(k);
  endfunction

  // array id reduced modulo the number of table rows (MAX_ARRAYS)
  logic [AW-1:0] id_mod [aag_pkg::ID_VALUES];
  for (genvar v = 0; v < aag_pkg::ID_VALUES; v++) begin : g_id_mod
    localparam int Rem = v % MAX_ARRAYS;
    assign id_mod[v] = AW'(Rem);
  end

  logic [AW-1:0] id_red;
  logic [DW-1:0] d_sat;

  assign id_red = id_mod[array_id_i];

  always_comb begin
    if (dim_count_i == '0) begin
      d_sat = DW'(1);
    end else if (int'(dim_count_i) > MAX_DIMS) begin
      d_sat = DW'(MAX_DIMS);
    end else begin
      d_sat = DW'(dim_count_i);
    end
  end

  // control registers
  logic [TAW-1:0] clr_addr_q;
  logic [DW-1:0]  dc_q;
  logic [DW-1:0]  bc_q;
  logic           defining_q;
  logic           out_valid_q;
  logic [DW-1:0]  dims_q [MAX_ARRAYS];

  // payload registers
  logic [AW-1:0]  target_q;
  logic [AW-1:0]  qid_q;
  logic [XW-1:0]  base_q;
  logic [DW-1:0]  def_dims_q;
  logic [XW-1:0]  esize_q;
  logic [LW-1:0]  k_q;
  logic [XW-1:0]  s_q;
  logic [XW-1:0]  sum_q;
  logic [XW-1:0]  ext_q;
  logic [XW-1:0]  sub_q;
  logic [XW-1:0]  acc_q;
  logic [aag_pkg::ID_W-1:0] out_id_q;
  logic [XW-1:0]  out_addr_q;

  // memories
  logic [XW-1:0]  tab_mem [TABLE_DEPTH];
  logic [XW-1:0]  lo_mem  [MAX_DIMS];
  logic [XW-1:0]  hi_mem  [MAX_DIMS];
  logic [XW-1:0]  tab_rd_q;
  logic [XW-1:0]  lo_rd_q;
  logic [XW-1:0]  hi_rd_q;

  logic           tab_we;
  logic [TAW-1:0] tab_waddr;
  logic [XW-1:0]  tab_wdata;
  logic [TAW-1:0] tab_raddr;
  logic [LW-1:0]  lu_raddr;

  // shared multiplier, low word only
  logic [XW-1:0]  mul_a;
  logic [XW-1:0]  mul_b;
  logic [XW-1:0]  prod;

  logic [DW-1:0]  q_dims;
  logic           mac_en;
  logic [DW-1:0]  dc_inc;
  logic [XW-1:0]  acc_next;
  logic           out_free;

  always_comb begin
    if (cmd_i.q_mac) begin
      mul_a = sub_q;
      mul_b = tab_rd_q;
    end else if (cmd_i.fin_str) begin
      mul_a = s_q;
      mul_b = ext_q;
    end else begin
      mul_a = s_q;
      mul_b = lo_rd_q;
    end
  end

  assign prod = mul_a * mul_b;

  assign q_dims   = dims_q[qid_q];
  assign mac_en   = (q_dims != '0) && (dc_q < q_dims);
  assign dc_inc   = dc_q + DW'(mac_en);
  assign acc_next = mac_en ? (acc_q + prod) : acc_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = clr_addr_q;
    tab_wdata = '0;
    if (cmd_i.clear_en) begin
      tab_we = 1'b1;
    end else if (cmd_i.def_load) begin
      tab_we    = 1'b1;
      tab_waddr = tab_addr(id_red, KW'(d_sat));
      tab_wdata = {1'b0, elem_bytes_i};
    end else if (cmd_i.fin_str) begin
      tab_we    = 1'b1;
      tab_waddr = tab_addr(target_q, KW'(k_q));
      tab_wdata = prod;
    end else if (cmd_i.fin_const) begin
      tab_we    = 1'b1;
      tab_waddr = tab_addr(target_q, KW'(0));
      tab_wdata = base_q - sum_q;
    end
  end

  // first subscript of a query fetches the constant, later ones the next stride
  assign tab_raddr = (cmd_i.sub_accept && (dc_q == '0)) ? tab_addr(id_red, KW'(0))
                   : tab_addr(qid_q, KW'(dc_q) + KW'(1));
  assign lu_raddr  = cmd_i.fin_str ? (k_q - LW'(1)) : k_q;

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bound_load) begin
      lo_mem[bc_q[LW-1:0]] <= lower_bound_i;
      hi_mem[bc_q[LW-1:0]] <= upper_bound_i;
    end
    lo_rd_q <= lo_mem[lu_raddr];
    hi_rd_q <= hi_mem[lu_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      dc_q        <= '0;
      bc_q        <= '0;
      defining_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ARRAYS; i++) begin
        dims_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear_en) clr_addr_q <= clr_addr_q + TAW'(1);
      if (cmd_i.def_load) begin
        dims_q[id_red] <= d_sat;
        bc_q           <= '0;
        defining_q     <= 1'b1;
      end
      if (cmd_i.bound_load) bc_q <= bc_q + DW'(1);
      if (cmd_i.fin_start) defining_q <= 1'b0;
      if (cmd_i.q_mac) begin
        dc_q <= (dc_inc >= q_dims) ? '0 : dc_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.def_load) begin
      target_q   <= id_red;
      base_q     <= base_address_i;
      esize_q    <= {1'b0, elem_bytes_i};
      def_dims_q <= d_sat;
    end
    if (cmd_i.fin_start) begin
      k_q   <= LW'(def_dims_q - DW'(1));
      s_q   <= esize_q;
      sum_q <= '0;
    end
    if (cmd_i.fin_sum) begin
      sum_q <= sum_q + prod;
      ext_q <= hi_rd_q - lo_rd_q + XW'(1);
    end
    if (cmd_i.fin_str) begin
      s_q <= prod;
      k_q <= k_q - LW'(1);
    end
    if (cmd_i.sub_accept) begin
      sub_q <= subscript_i;
      if (dc_q == '0) qid_q <= id_red;
    end
    if (cmd_i.q_const) acc_q <= tab_rd_q;
    if (cmd_i.q_mac) acc_q <= acc_next;
    if (cmd_i.out_load) begin
      out_id_q   <= aag_pkg::ID_W'(qid_q);
      out_addr_q <= cmd_i.q_mac ? acc_next : acc_q;
    end
  end

  assign status_o.clear_last = (clr_addr_q == TAW'(TABLE_DEPTH - 1));
  assign status_o.defining   = defining_q;
  assign status_o.bound_last = (bc_q + DW'(1)) >= def_dims_q;
  assign status_o.dc_zero    = (dc_q == '0);
  assign status_o.emit       = (dc_inc >= q_dims);
  assign status_o.out_free   = out_free;
  assign status_o.k_zero     = (k_q == '0);

  assign out_valid_o        = out_valid_q;
  assign out_array_id_res_o = out_id_q;
  assign out_address_o      = out_addr_q;

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  a_query_has_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dc_q != '0) |-> (dims_q[qid_q] != '0))
    else $error("query in progress on an array without dimensions");

  a_bound_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    defining_q |-> (bc_q < def_dims_q))
    else $error("bound count ran past dimension count");

  a_fin_closes_define: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_start |=> !defining_q)
    else $error("definition still open after last bound");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_sum |-> (DW'(k_q) < def_dims_q))
    else $error("stride walk index outside the definition");

endmodule

`default_nettype wire
